### hw/rtl/pit_pkg.sv
// Shared types and constants for the prescaled interval timer.
// No dependencies; used by the channel interfaces, pit_regs and the top level.
package pit_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [3:0] OFS_MODE     = 4'h0;
  localparam logic [3:0] OFS_CLK      = 4'h2;
  localparam logic [3:0] OFS_PRESCALE = 4'h4;
  localparam logic [3:0] OFS_MAX      = 4'h6;
  localparam logic [3:0] OFS_TRIGGER  = 4'h8;
  localparam logic [3:0] OFS_COUNT    = 4'hA;

  localparam logic [1:0] RUN_STOP    = 2'd0;
  localparam logic [1:0] RUN_ONESHOT = 2'd1;
  localparam logic [1:0] RUN_FREE    = 2'd2;

  localparam int PRESCALE_FIELD_W = 10;
  localparam int DATA_W           = 16;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        reg_offset;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
  } result_t;

endpackage

### hw/rtl/pit_ifs.sv
// Valid/ready channel interfaces for the timer's input and result words.
// Depends on pit_pkg for the data width.
interface pit_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [3:0]                  reg_offset;
  logic [pit_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output mode, output reg_offset, output write_data,
                  input ready);
  modport sink (input valid, input mode, input reg_offset, input write_data,
                output ready);
endinterface

interface pit_out_if;
  logic                        valid;
  logic                        ready;
  logic [pit_pkg::DATA_W-1:0]  read_data;
  logic                        irq;

  modport source (output valid, output read_data, output irq, input ready);
  modport sink (input valid, input read_data, input irq, output ready);
endinterface

### hw/rtl/pit_regs.sv
// Timer register bank and counters: decodes one word and updates state on commit.
// Depends on pit_pkg for the word and result types, offsets and run modes.
module pit_regs #(
  parameter int PRESCALE_SHIFT = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             commit,
  input  pit_pkg::item_t   item,
  output pit_pkg::result_t res
);

  localparam int LIM_W = pit_pkg::PRESCALE_FIELD_W - PRESCALE_SHIFT;
  localparam int DW    = pit_pkg::DATA_W;

  logic [1:0]       run_mode_r, run_mode_nxt;
  logic             clk_sel_r, clk_sel_nxt;
  logic [LIM_W-1:0] pre_lim_r, pre_lim_nxt;
  logic [DW-1:0]    cnt_max_r, cnt_max_nxt;
  logic             go_r, go_nxt;
  logic [DW-1:0]    tick_cnt_r, tick_cnt_nxt;
  logic [LIM_W-1:0] pre_cnt_r, pre_cnt_nxt;

  logic [LIM_W:0]   pre_inc;
  logic [DW:0]      tick_inc;
  logic             running;
  logic             fire;

  always_comb begin
    run_mode_nxt = run_mode_r;
    clk_sel_nxt  = clk_sel_r;
    pre_lim_nxt  = pre_lim_r;
    cnt_max_nxt  = cnt_max_r;
    go_nxt       = go_r;
    tick_cnt_nxt = tick_cnt_r;
    pre_cnt_nxt  = pre_cnt_r;
    fire         = 1'b0;
    res          = '0;
    pre_inc      = {1'b0, pre_cnt_r} + {{LIM_W{1'b0}}, 1'b1};
    tick_inc     = {1'b0, tick_cnt_r} + {{DW{1'b0}}, 1'b1};
    running      = ((run_mode_r == pit_pkg::RUN_ONESHOT) && go_r) ||
                   (run_mode_r == pit_pkg::RUN_FREE);
    case (item.kind)
      pit_pkg::KIND_TICK: begin
        if (running) begin
          if (pre_inc < {1'b0, pre_lim_r}) begin
            pre_cnt_nxt = pre_inc[LIM_W-1:0];
          end else begin
            pre_cnt_nxt = '0;
            if (tick_inc >= {1'b0, cnt_max_r}) begin
              tick_cnt_nxt = '0;
              fire         = 1'b1;
              if (run_mode_r == pit_pkg::RUN_ONESHOT) begin
                go_nxt = 1'b0;
              end
            end else begin
              tick_cnt_nxt = tick_inc[DW-1:0];
            end
          end
        end
        res.irq = fire;
      end
      pit_pkg::KIND_READ: begin
        case (item.reg_offset)
          pit_pkg::OFS_MODE:     res.read_data = {{(DW-2){1'b0}}, run_mode_r};
          pit_pkg::OFS_CLK:      res.read_data = {{(DW-1){1'b0}}, clk_sel_r};
          pit_pkg::OFS_PRESCALE: res.read_data = {{(DW-LIM_W){1'b0}}, pre_lim_r};
          pit_pkg::OFS_MAX:      res.read_data = cnt_max_r;
          pit_pkg::OFS_COUNT:    res.read_data = tick_cnt_r;
          default:               res.read_data = '0;
        endcase
      end
      pit_pkg::KIND_WRITE: begin
        case (item.reg_offset)
          pit_pkg::OFS_MODE: begin
            run_mode_nxt = item.write_data[1:0];
            tick_cnt_nxt = '0;
            pre_cnt_nxt  = '0;
          end
          pit_pkg::OFS_CLK: begin
            clk_sel_nxt = item.write_data[0];
          end
          pit_pkg::OFS_PRESCALE: begin
            pre_lim_nxt = item.write_data[pit_pkg::PRESCALE_FIELD_W-1:PRESCALE_SHIFT];
          end
          pit_pkg::OFS_MAX: begin
            cnt_max_nxt = item.write_data;
          end
          pit_pkg::OFS_TRIGGER: begin
            go_nxt       = item.write_data[0];
            tick_cnt_nxt = '0;
            pre_cnt_nxt  = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r <= pit_pkg::RUN_STOP;
      clk_sel_r  <= 1'b0;
      pre_lim_r  <= '0;
      cnt_max_r  <= '0;
      go_r       <= 1'b0;
      tick_cnt_r <= '0;
      pre_cnt_r  <= '0;
    end else if (commit) begin
      run_mode_r <= run_mode_nxt;
      clk_sel_r  <= clk_sel_nxt;
      pre_lim_r  <= pre_lim_nxt;
      cnt_max_r  <= cnt_max_nxt;
      go_r       <= go_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      pre_cnt_r  <= pre_cnt_nxt;
    end
  end

  a_fire_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    commit && fire |=> tick_cnt_r == '0)
    else $error("count not wrapped after irq");

  a_oneshot_clears_go: assert property (@(posedge clk) disable iff (!rst_n)
    commit && fire && (run_mode_r == pit_pkg::RUN_ONESHOT) |=> !go_r)
    else $error("one-shot trigger not cleared after irq");

  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (item.kind == pit_pkg::KIND_TICK) && !running |=> $stable(tick_cnt_r))
    else $error("count moved while stopped");

  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    res.irq |-> item.kind == pit_pkg::KIND_TICK)
    else $error("irq raised for a bus access");

endmodule

### hw/rtl/prescaled_interval_timer_core.sv
// Prescaled interval timer: input register, register bank/counters, result register.
// Depends on pit_pkg, pit_in_if/pit_out_if and pit_regs.
// Path: input word to the input register, then its result to the result register.
// Throughput: one word/cycle unless stalled; result reg frees while its word is taken.
// Reset: synchronous active-low rst_n clears all timer registers and both valid flags.
module prescaled_interval_timer_core #(
  parameter int PRESCALE_SHIFT = 1
) (
  input logic       clk,
  input logic       rst_n,
  pit_in_if.sink    in_bus,
  pit_out_if.source out_bus
);

  logic              s1_v_r;
  pit_pkg::item_t    s1_item_r;
  logic              out_v_r;
  pit_pkg::result_t  out_res_r;
  pit_pkg::result_t  res;
  logic              adv;
  logic              commit;
  logic              in_take;

  assign adv     = !out_v_r || out_bus.ready;
  assign commit  = s1_v_r && adv;
  assign in_bus.ready = !s1_v_r || adv;
  assign in_take = in_bus.valid && in_bus.ready;

  assign out_bus.valid     = out_v_r;
  assign out_bus.read_data = out_res_r.read_data;
  assign out_bus.irq       = out_res_r.irq;

  pit_regs #(
    .PRESCALE_SHIFT(PRESCALE_SHIFT)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .item   (s1_item_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.kind       <= pit_pkg::kind_t'(in_bus.mode);
      s1_item_r.reg_offset <= in_bus.reg_offset;
      s1_item_r.write_data <= in_bus.write_data;
    end
    if (commit) begin
      out_res_r <= res;
    end
  end

  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.irq |-> out_res_r.read_data == '0)
    else $error("irq word carries read data");

  a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_v_r)
    else $error("result word lost");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_item_r))
    else $error("input stage dropped a word under stall");

endmodule

### tb/prescaled_interval_timer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for prescaled_interval_timer_core: directed rows, then random phases.
// Depends on pit_pkg and the pit_in_if/pit_out_if channel interfaces.
module prescaled_interval_timer_core_tb;

  localparam int PRESCALE_SHIFT = 1;
  localparam int ROWS = 29;
  localparam int PHASES = 5;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct {
    pit_pkg::kind_t   kind;
    logic [3:0]       ofs;
    logic [15:0]      data;
    bit               fixed;
    pit_pkg::result_t res;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;

  pit_in_if  in_ch ();
  pit_out_if out_ch ();

  prescaled_interval_timer_core #(
    .PRESCALE_SHIFT(PRESCALE_SHIFT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer state as the block should hold it
  logic [1:0]  run_mode   = pit_pkg::RUN_STOP;
  logic        clk_sel    = 1'b0;
  logic [9:0]  pre_limit  = '0;
  logic [15:0] cnt_max    = '0;
  logic        go_flag    = 1'b0;
  logic [15:0] tick_cnt   = '0;
  logic [10:0] pre_cnt    = '0;

  vector_t          row_results[$];
  pit_pkg::result_t pending_results[$];
  int               mismatches = 0;
  int               in_idle_pct = 0;
  int               out_stall_pct = 0;
  bit               long_hold = 1'b0;
  bit               hold_done = 1'b0;

  vector_t directed_rows [ROWS] = '{
    '{pit_pkg::KIND_READ,  pit_pkg::OFS_MODE,     16'h0000, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_TICK,  pit_pkg::OFS_MODE,     16'h0000, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_PRESCALE, 16'hFFFF, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_READ,  pit_pkg::OFS_PRESCALE, 16'h0000, 1'b1, {16'h01FF, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_PRESCALE, 16'h0000, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_MODE, {14'd0, pit_pkg::RUN_FREE},
      1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_TICK,  pit_pkg::OFS_MODE,     16'h0000, 1'b1, {16'h0000, 1'b1}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_MAX,      16'h0002, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_TICK,  pit_pkg::OFS_MODE,     16'h0000, 1'b0, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_TICK,  pit_pkg::OFS_MODE,     16'h0000, 1'b0, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_COUNT,    16'h1234, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_READ,  pit_pkg::OFS_COUNT,    16'h0000, 1'b0, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_CLK,      16'hFFFF, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_READ,  pit_pkg::OFS_CLK,      16'h0000, 1'b1, {16'h0001, 1'b0}},
    '{pit_pkg::KIND_READ,  pit_pkg::OFS_TRIGGER,  16'h0000, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_READ,  4'hF,                  16'h0000, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_MODE,     16'h0003, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_TICK,  pit_pkg::OFS_MODE,     16'h0000, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_READ,  pit_pkg::OFS_MODE,     16'h0000, 1'b1, {16'h0003, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_MODE, {14'd0, pit_pkg::RUN_ONESHOT},
      1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_MAX,      16'h0001, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_TRIGGER,  16'h0001, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_TICK,  pit_pkg::OFS_MODE,     16'h0000, 1'b0, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_NONE,  4'hF,                  16'hFFFF, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_MAX,      16'hFFFF, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_MODE, {14'd0, pit_pkg::RUN_FREE},
      1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_TICK,  pit_pkg::OFS_MODE,     16'h0000, 1'b0, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_WRITE, pit_pkg::OFS_MAX,      16'h0000, 1'b1, {16'h0000, 1'b0}},
    '{pit_pkg::KIND_TICK,  pit_pkg::OFS_MODE,     16'h0000, 1'b0, {16'h0000, 1'b0}}
  };

  int phase_in_idle   [PHASES] = '{0, 88, 0, 9, 0};
  int phase_out_stall [PHASES] = '{0, 0, 88, 9, 0};
  int phase_words     [PHASES] = '{450, 400, 400, 400, 300};

  function automatic logic advance_count();
    logic [16:0] nxt;
    pre_cnt = pre_cnt + 11'd1;
    if (pre_cnt < {1'b0, pre_limit}) return 1'b0;
    pre_cnt = '0;
    nxt = {1'b0, tick_cnt} + 17'd1;
    if (nxt >= {1'b0, cnt_max}) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = nxt[15:0];
    return 1'b0;
  endfunction

  function automatic pit_pkg::result_t timer_response(input pit_pkg::item_t w);
    pit_pkg::result_t r;
    r = '0;
    case (w.kind)
      pit_pkg::KIND_TICK: begin
        if (run_mode == pit_pkg::RUN_ONESHOT && go_flag) begin
          r.irq = advance_count();
          if (r.irq) go_flag = 1'b0;
        end else if (run_mode == pit_pkg::RUN_FREE) begin
          r.irq = advance_count();
        end
      end
      pit_pkg::KIND_READ: begin
        case (w.reg_offset)
          pit_pkg::OFS_MODE:     r.read_data = {14'd0, run_mode};
          pit_pkg::OFS_CLK:      r.read_data = {15'd0, clk_sel};
          pit_pkg::OFS_PRESCALE: r.read_data = {6'd0, pre_limit};
          pit_pkg::OFS_MAX:      r.read_data = cnt_max;
          pit_pkg::OFS_COUNT:    r.read_data = tick_cnt;
          default:               r.read_data = '0;
        endcase
      end
      pit_pkg::KIND_WRITE: begin
        case (w.reg_offset)
          pit_pkg::OFS_MODE: begin
            run_mode = w.write_data[1:0];
            tick_cnt = '0;
            pre_cnt  = '0;
          end
          pit_pkg::OFS_CLK:      clk_sel = w.write_data[0];
          pit_pkg::OFS_PRESCALE: pre_limit = w.write_data[9:0] >> PRESCALE_SHIFT;
          pit_pkg::OFS_MAX:      cnt_max = w.write_data;
          pit_pkg::OFS_TRIGGER: begin
            go_flag  = w.write_data[0];
            tick_cnt = '0;
            pre_cnt  = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] pick_offset();
    case ($urandom_range(5))
      0:       return pit_pkg::OFS_MODE;
      1:       return pit_pkg::OFS_CLK;
      2:       return pit_pkg::OFS_PRESCALE;
      3:       return pit_pkg::OFS_MAX;
      4:       return pit_pkg::OFS_TRIGGER;
      default: return pit_pkg::OFS_COUNT;
    endcase
  endfunction

  // mostly ticks and well-formed register traffic with small limits, some noise
  function automatic pit_pkg::item_t random_word();
    pit_pkg::item_t w;
    int pick;
    w.kind = pit_pkg::KIND_TICK;
    w.reg_offset = 4'($urandom);
    w.write_data = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 58) begin
      w.kind = pit_pkg::KIND_TICK;
    end else if (pick < 72) begin
      w.kind = pit_pkg::KIND_READ;
      w.reg_offset = pick_offset();
    end else if (pick < 90) begin
      w.kind = pit_pkg::KIND_WRITE;
      w.reg_offset = pick_offset();
      case (w.reg_offset)
        pit_pkg::OFS_MODE:
          if ($urandom_range(9) < 8) w.write_data[1:0] = $urandom_range(1, 2) == 1 ?
                                                        pit_pkg::RUN_ONESHOT :
                                                        pit_pkg::RUN_FREE;
        pit_pkg::OFS_PRESCALE:
          if ($urandom_range(9) < 8) w.write_data = 16'($urandom_range(9));
        pit_pkg::OFS_MAX:
          if ($urandom_range(9) < 8) w.write_data = 16'($urandom_range(12));
        pit_pkg::OFS_TRIGGER:
          if ($urandom_range(9) < 8) w.write_data[0] = 1'b1;
        default: ;
      endcase
    end else if (pick < 96) begin
      w.kind = $urandom_range(1) ? pit_pkg::KIND_WRITE : pit_pkg::KIND_READ;
    end else begin
      w.kind = pit_pkg::KIND_NONE;
    end
    return w;
  endfunction

  task automatic send_word(input pit_pkg::item_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= w.kind;
    in_ch.reg_offset <= w.reg_offset;
    in_ch.write_data <= w.write_data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // predict on input words, check result words in order
  always @(posedge clk) begin : scoreboard
    pit_pkg::item_t   w;
    vector_t          v;
    pit_pkg::result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        w.kind       = pit_pkg::kind_t'(in_ch.mode);
        w.reg_offset = in_ch.reg_offset;
        w.write_data = in_ch.write_data;
        v = row_results.pop_front();
        want = timer_response(w);
        pending_results.push_back(v.fixed ? v.res : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word read_data=%h irq=%b", $time,
                   out_ch.read_data, out_ch.irq);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.read_data !== want.read_data) begin
            mismatches++;
            $display("%0t: read_data expected %h actual %h", $time,
                     want.read_data, out_ch.read_data);
          end
          if (out_ch.irq !== want.irq) begin
            mismatches++;
            $display("%0t: irq expected %b actual %b", $time, want.irq, out_ch.irq);
          end
        end
      end
    end
  end

  // result sink: random stalls, one long hold-off in the last phase
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  initial begin
    vector_t        v;
    pit_pkg::item_t w;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= pit_pkg::KIND_TICK;
    in_ch.reg_offset <= '0;
    in_ch.write_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < ROWS; i++) begin
      v = directed_rows[i];
      w.kind       = v.kind;
      w.reg_offset = v.ofs;
      w.write_data = v.data;
      row_results.push_back(v);
      send_word(w);
    end

    for (int p = 0; p < PHASES; p++) begin
      in_idle_pct   = phase_in_idle[p];
      out_stall_pct = phase_out_stall[p];
      long_hold     = (p == PHASES - 1);
      for (int n = 0; n < phase_words[p]; n++) begin
        w = random_word();
        v.fixed = 1'b0;
        v.res   = '0;
        row_results.push_back(v);
        send_word(w);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
